FILE: hdl/hrsp_pkg.sv
// hrsp_pkg: shared types, character codes and header name and value texts for the
// HTTP request stream parser. No dependencies.
`timescale 1ns / 1ps

package hrsp_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_PENDING = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   // Phase codes as they appear on the result port
   localparam logic [1:0] PHASE_CODE_REQ  = 2'd0;
   localparam logic [1:0] PHASE_CODE_HDR  = 2'd1;
   localparam logic [1:0] PHASE_CODE_BODY = 2'd2;

   // Character codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Match texts, left aligned and zero padded to sixteen characters
   localparam logic [127:0] CONN_TEXT = {"Connection", 48'h0};
   localparam logic [127:0] CLEN_TEXT = {"Content-Length", 16'h0};
   localparam logic [127:0] HOST_TEXT = {"Host", 96'h0};
   localparam logic [127:0] KA_TEXT   = {"keep-alive", 48'h0};

   localparam logic [3:0] CONN_LEN     = 4'd10;
   localparam logic [3:0] CLEN_LEN     = 4'd14;
   localparam logic [3:0] HOST_LEN     = 4'd4;
   localparam logic [3:0] KA_LEN       = 4'd10;
   localparam logic [3:0] MATCH_IDX_MAX = 4'd15;

   // Parse phase, one-hot
   typedef enum logic [2:0] {
      PH_REQ  = 3'b001,
      PH_HDR  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   // Position within a line, one-hot
   typedef enum logic [2:0] {
      SUB_FIRST  = 3'b001,
      SUB_SECOND = 3'b010,
      SUB_THIRD  = 3'b100
   } sub_type;

   // Frame control to header matcher
   typedef struct packed {
      logic clear;
      logic name_byte;
      logic colon;
      logic value_byte;
   } match_ctrl_type;

   // Header matcher status back to frame control
   typedef struct packed {
      logic conn_hit;
      logic clen_hit;
      logic host_hit;
      logic ka_match;
   } match_info_type;

   function automatic logic [7:0] pick_char(logic [127:0] text, logic [3:0] idx);
      pick_char = text[(15 - idx) * 8 +: 8];
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      is_blank = (c == CHAR_SP) || (c == CHAR_TAB);
   endfunction

   function automatic logic [1:0] phase_code(phase_type ph);
      case (ph)
         PH_REQ:  phase_code = PHASE_CODE_REQ;
         PH_HDR:  phase_code = PHASE_CODE_HDR;
         PH_BODY: phase_code = PHASE_CODE_BODY;
         default: phase_code = PHASE_CODE_REQ;
      endcase
   endfunction

endpackage

FILE: hdl/hrsp_field_match.sv
// hrsp_field_match: header name recogniser, keep-alive value matcher and
// saturating decimal accumulator. Depends on hrsp_pkg.
`timescale 1ns / 1ps

module hrsp_field_match
   import hrsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  match_ctrl_type         ctrl,
   input  logic [7:0]             data_byte,
   output match_info_type         info,
   output logic [LENGTH_BITS-1:0] length_value
);

   logic [3:0]             name_idx_ff, name_idx_in;
   logic [2:0]             name_flags_ff, name_flags_in;
   logic [3:0]             val_idx_ff, val_idx_in;
   logic                   val_flag_ff, val_flag_in;
   logic                   digits_ff, digits_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;

   logic [LENGTH_BITS+3:0] acc_wide;
   logic                   is_digit;

   // acc * 10 + digit, four guard bits to spot overflow
   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + {{LENGTH_BITS{1'b0}}, data_byte[3:0]};

   // Next match state
   always_comb begin
      name_idx_in   = name_idx_ff;
      name_flags_in = name_flags_ff;
      val_idx_in    = val_idx_ff;
      val_flag_in   = val_flag_ff;
      digits_in     = digits_ff;
      acc_in        = acc_ff;
      if (ctrl.clear) begin
         name_idx_in   = '0;
         name_flags_in = 3'b111;
         val_idx_in    = '0;
         val_flag_in   = 1'b1;
         digits_in     = 1'b1;
         acc_in        = '0;
      end else if (ctrl.name_byte) begin
         if ((name_idx_ff >= CONN_LEN) || (data_byte != pick_char(CONN_TEXT, name_idx_ff)))
            name_flags_in[0] = 1'b0;
         if ((name_idx_ff >= CLEN_LEN) || (data_byte != pick_char(CLEN_TEXT, name_idx_ff)))
            name_flags_in[1] = 1'b0;
         if ((name_idx_ff >= HOST_LEN) || (data_byte != pick_char(HOST_TEXT, name_idx_ff)))
            name_flags_in[2] = 1'b0;
         if (name_idx_ff < MATCH_IDX_MAX)
            name_idx_in = name_idx_ff + 4'd1;
      end else if (ctrl.colon) begin
         // name must end exactly at its full length
         if (name_idx_ff != CONN_LEN) name_flags_in[0] = 1'b0;
         if (name_idx_ff != CLEN_LEN) name_flags_in[1] = 1'b0;
         if (name_idx_ff != HOST_LEN) name_flags_in[2] = 1'b0;
      end else if (ctrl.value_byte) begin
         if (val_flag_ff && ((val_idx_ff >= KA_LEN)
                             || (data_byte != pick_char(KA_TEXT, val_idx_ff))))
            val_flag_in = 1'b0;
         if (val_idx_ff < MATCH_IDX_MAX)
            val_idx_in = val_idx_ff + 4'd1;
         if (digits_ff) begin
            if (!is_digit)
               digits_in = 1'b0;
            else if (acc_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
               acc_in = '1;
            else
               acc_in = acc_wide[LENGTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_idx_ff   <= '0;
         name_flags_ff <= 3'b111;
         val_idx_ff    <= '0;
         val_flag_ff   <= 1'b1;
         digits_ff     <= 1'b1;
         acc_ff        <= '0;
      end else begin
         name_idx_ff   <= name_idx_in;
         name_flags_ff <= name_flags_in;
         val_idx_ff    <= val_idx_in;
         val_flag_ff   <= val_flag_in;
         digits_ff     <= digits_in;
         acc_ff        <= acc_in;
      end
   end

   assign info.conn_hit = name_flags_ff[0];
   assign info.clen_hit = name_flags_ff[1];
   assign info.host_hit = name_flags_ff[2];
   assign info.ka_match = val_flag_ff && (val_idx_ff == KA_LEN);
   assign length_value  = acc_ff;

endmodule

FILE: hdl/hrsp_frame_ctrl.sv
// hrsp_frame_ctrl: line framing, phase tracking, span registers and body
// count; drives the header matcher. Depends on hrsp_pkg, hrsp_field_match.
`timescale 1ns / 1ps

module hrsp_frame_ctrl
   import hrsp_pkg::*;
#(
   parameter int OFFSET_BITS = 16,
   parameter int LENGTH_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   output logic [1:0]             nxt_status,
   output logic [1:0]             nxt_phase,
   output logic                   nxt_persist,
   output logic [LENGTH_BITS-1:0] nxt_decl_length,
   output logic [OFFSET_BITS-1:0] nxt_method_len,
   output logic [OFFSET_BITS-1:0] nxt_url_start,
   output logic [OFFSET_BITS-1:0] nxt_url_len,
   output logic [OFFSET_BITS-1:0] nxt_version_start,
   output logic [OFFSET_BITS-1:0] nxt_version_len,
   output logic [OFFSET_BITS-1:0] nxt_host_start,
   output logic [OFFSET_BITS-1:0] nxt_host_len
);

   localparam logic [OFFSET_BITS-1:0] OFF_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   phase_type              phase_ff, phase_in;
   sub_type                sub_ff, sub_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] line_start_ff, line_start_in;
   logic                   last_cr_ff, last_cr_in;
   logic                   err_ff, err_in;
   logic                   persist_ff, persist_in;
   logic [LENGTH_BITS-1:0] body_count_ff, body_count_in;
   logic [LENGTH_BITS-1:0] body_length_ff, body_length_in;
   logic [OFFSET_BITS-1:0] method_len_ff, method_len_in;
   logic [OFFSET_BITS-1:0] url_start_ff, url_start_in;
   logic [OFFSET_BITS-1:0] url_len_ff, url_len_in;
   logic [OFFSET_BITS-1:0] ver_start_ff, ver_start_in;
   logic [OFFSET_BITS-1:0] ver_len_ff, ver_len_in;
   logic [OFFSET_BITS-1:0] host_start_ff, host_start_in;
   logic [OFFSET_BITS-1:0] host_len_ff, host_len_in;
   logic [OFFSET_BITS-1:0] val_start_ff, val_start_in;

   match_ctrl_type         mctrl;
   match_info_type         minfo;
   logic [LENGTH_BITS-1:0] length_value;
   logic [OFFSET_BITS-1:0] cr_pos;
   logic                   blank;
   logic                   end_ok;

   hrsp_field_match #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (mctrl),
      .data_byte    (data_byte),
      .info         (minfo),
      .length_value (length_value)
   );

   assign cr_pos = pos_ff - OFF_ONE;
   assign blank  = is_blank(data_byte);

   // Per-byte state update
   always_comb begin
      mctrl          = '0;
      end_ok         = 1'b0;
      phase_in       = phase_ff;
      sub_in         = sub_ff;
      pos_in         = pos_ff;
      line_start_in  = line_start_ff;
      last_cr_in     = last_cr_ff;
      err_in         = err_ff;
      persist_in     = persist_ff;
      body_count_in  = body_count_ff;
      body_length_in = body_length_ff;
      method_len_in  = method_len_ff;
      url_start_in   = url_start_ff;
      url_len_in     = url_len_ff;
      ver_start_in   = ver_start_ff;
      ver_len_in     = ver_len_ff;
      host_start_in  = host_start_ff;
      host_len_in    = host_len_ff;
      val_start_in   = val_start_ff;

      if (step && !err_ff) begin
         if (phase_ff == PH_BODY) begin
            if (body_count_ff < body_length_ff)
               body_count_in = body_count_ff + LEN_ONE;
         end else if (pos_ff == '1) begin
            // message too long for the offset counters
            err_in = 1'b1;
         end else begin
            pos_in = pos_ff + OFF_ONE;
            if (last_cr_ff) begin
               last_cr_in = 1'b0;
               if (data_byte != CHAR_LF) begin
                  err_in = 1'b1;
               end else begin
                  // end of line
                  case (phase_ff)
                     PH_REQ: begin
                        if (sub_ff != SUB_THIRD) begin
                           err_in = 1'b1;
                        end else begin
                           ver_len_in = cr_pos - ver_start_ff;
                           phase_in   = PH_HDR;
                           end_ok     = 1'b1;
                        end
                     end
                     PH_HDR: begin
                        if (cr_pos == line_start_ff) begin
                           phase_in      = PH_BODY;
                           body_count_in = '0;
                           end_ok        = 1'b1;
                        end else if (sub_ff != SUB_THIRD) begin
                           err_in = 1'b1;
                        end else begin
                           if (minfo.conn_hit) persist_in = minfo.ka_match;
                           if (minfo.clen_hit) body_length_in = length_value;
                           if (minfo.host_hit) begin
                              host_start_in = val_start_ff;
                              host_len_in   = cr_pos - val_start_ff;
                           end
                           end_ok = 1'b1;
                        end
                     end
                     default: ;
                  endcase
                  if (end_ok) begin
                     sub_in        = SUB_FIRST;
                     line_start_in = pos_ff + OFF_ONE;
                     mctrl.clear   = 1'b1;
                  end
               end
            end else if (data_byte == CHAR_CR) begin
               last_cr_in = 1'b1;
            end else begin
               // ordinary line byte
               case (phase_ff)
                  PH_REQ: begin
                     if ((sub_ff == SUB_FIRST) && blank) begin
                        method_len_in = pos_ff - line_start_ff;
                        url_start_in  = pos_ff + OFF_ONE;
                        sub_in        = SUB_SECOND;
                     end else if ((sub_ff == SUB_SECOND) && blank) begin
                        url_len_in   = pos_ff - url_start_ff;
                        ver_start_in = pos_ff + OFF_ONE;
                        sub_in       = SUB_THIRD;
                     end
                  end
                  PH_HDR: begin
                     case (sub_ff)
                        SUB_FIRST: begin
                           if (data_byte == CHAR_COLON) begin
                              mctrl.colon = 1'b1;
                              sub_in      = SUB_SECOND;
                           end else begin
                              mctrl.name_byte = 1'b1;
                           end
                        end
                        SUB_SECOND: begin
                           if (!blank) begin
                              val_start_in     = pos_ff;
                              sub_in           = SUB_THIRD;
                              mctrl.value_byte = 1'b1;
                           end
                        end
                        default: mctrl.value_byte = 1'b1;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_REQ;
         sub_ff         <= SUB_FIRST;
         pos_ff         <= '0;
         line_start_ff  <= '0;
         last_cr_ff     <= 1'b0;
         err_ff         <= 1'b0;
         persist_ff     <= 1'b0;
         body_count_ff  <= '0;
         body_length_ff <= '0;
         method_len_ff  <= '0;
         url_start_ff   <= '0;
         url_len_ff     <= '0;
         ver_start_ff   <= '0;
         ver_len_ff     <= '0;
         host_start_ff  <= '0;
         host_len_ff    <= '0;
         val_start_ff   <= '0;
      end else begin
         phase_ff       <= phase_in;
         sub_ff         <= sub_in;
         pos_ff         <= pos_in;
         line_start_ff  <= line_start_in;
         last_cr_ff     <= last_cr_in;
         err_ff         <= err_in;
         persist_ff     <= persist_in;
         body_count_ff  <= body_count_in;
         body_length_ff <= body_length_in;
         method_len_ff  <= method_len_in;
         url_start_ff   <= url_start_in;
         url_len_ff     <= url_len_in;
         ver_start_ff   <= ver_start_in;
         ver_len_ff     <= ver_len_in;
         host_start_ff  <= host_start_in;
         host_len_ff    <= host_len_in;
         val_start_ff   <= val_start_in;
      end
   end

   // Result fields follow the updated state
   always_comb begin
      if (err_in)
         nxt_status = STATUS_BAD;
      else if ((phase_in == PH_BODY) && (body_count_in >= body_length_in))
         nxt_status = STATUS_DONE;
      else
         nxt_status = STATUS_PENDING;
   end

   assign nxt_phase          = phase_code(phase_in);
   assign nxt_persist        = persist_in;
   assign nxt_decl_length    = body_length_in;
   assign nxt_method_len     = method_len_in;
   assign nxt_url_start      = url_start_in;
   assign nxt_url_len        = url_len_in;
   assign nxt_version_start  = ver_start_in;
   assign nxt_version_len    = ver_len_in;
   assign nxt_host_start     = host_start_in;
   assign nxt_host_len       = host_len_in;

endmodule

FILE: hdl/http_request_stream_parser.sv
// http_request_stream_parser: top level with input register, result
// register and handshake. Depends on hrsp_pkg, hrsp_frame_ctrl.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_data_byte
//   rsp_      out        rsp_valid/rsp_stall   status, phase, persist,
//                                               decl_length, spans
//
// One byte a cycle sustained while rsp_stall is low: a transaction is held in
// the input register, processed by the framing logic and written to the result
// register; rsp_valid rises when the result register is written.
// A stalled result holds the result register; one further transaction is
// taken into the input register before req_stall rises.
// Synchronous active-high reset returns the parser to the request line.

module http_request_stream_parser
   import hrsp_pkg::*;
#(
   parameter int OFFSET_BITS = 16,
   parameter int LENGTH_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [1:0]             rsp_phase,
   output logic                   rsp_persist,
   output logic [LENGTH_BITS-1:0] rsp_decl_length,
   output logic [OFFSET_BITS-1:0] rsp_method_len,
   output logic [OFFSET_BITS-1:0] rsp_url_start,
   output logic [OFFSET_BITS-1:0] rsp_url_len,
   output logic [OFFSET_BITS-1:0] rsp_version_start,
   output logic [OFFSET_BITS-1:0] rsp_version_len,
   output logic [OFFSET_BITS-1:0] rsp_host_start,
   output logic [OFFSET_BITS-1:0] rsp_host_len
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff;
   logic [1:0]             phase_ff;
   logic                   persist_ff;
   logic [LENGTH_BITS-1:0] decl_length_ff;
   logic [OFFSET_BITS-1:0] method_len_ff, url_start_ff, url_len_ff;
   logic [OFFSET_BITS-1:0] version_start_ff, version_len_ff;
   logic [OFFSET_BITS-1:0] host_start_ff, host_len_ff;

   logic                   req_take;
   logic                   advance;
   logic [1:0]             nxt_status, nxt_phase;
   logic                   nxt_persist;
   logic [LENGTH_BITS-1:0] nxt_decl_length;
   logic [OFFSET_BITS-1:0] nxt_method_len, nxt_url_start, nxt_url_len;
   logic [OFFSET_BITS-1:0] nxt_version_start, nxt_version_len;
   logic [OFFSET_BITS-1:0] nxt_host_start, nxt_host_len;

   // Handshake: process when the result register is free or draining
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   hrsp_frame_ctrl #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_frame (
      .clock              (clock),
      .reset              (reset),
      .step               (advance),
      .data_byte          (in_data_ff),
      .nxt_status         (nxt_status),
      .nxt_phase          (nxt_phase),
      .nxt_persist        (nxt_persist),
      .nxt_decl_length    (nxt_decl_length),
      .nxt_method_len     (nxt_method_len),
      .nxt_url_start      (nxt_url_start),
      .nxt_url_len        (nxt_url_len),
      .nxt_version_start  (nxt_version_start),
      .nxt_version_len    (nxt_version_len),
      .nxt_host_start     (nxt_host_start),
      .nxt_host_len       (nxt_host_len)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff         <= nxt_status;
         phase_ff          <= nxt_phase;
         persist_ff        <= nxt_persist;
         decl_length_ff    <= nxt_decl_length;
         method_len_ff     <= nxt_method_len;
         url_start_ff      <= nxt_url_start;
         url_len_ff        <= nxt_url_len;
         version_start_ff  <= nxt_version_start;
         version_len_ff    <= nxt_version_len;
         host_start_ff     <= nxt_host_start;
         host_len_ff       <= nxt_host_len;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_phase          = phase_ff;
   assign rsp_persist        = persist_ff;
   assign rsp_decl_length    = decl_length_ff;
   assign rsp_method_len     = method_len_ff;
   assign rsp_url_start      = url_start_ff;
   assign rsp_url_len        = url_len_ff;
   assign rsp_version_start  = version_start_ff;
   assign rsp_version_len    = version_len_ff;
   assign rsp_host_start     = host_start_ff;
   assign rsp_host_len       = host_len_ff;

   // Checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   a_free_path_takes: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |-> !req_stall)
      else $error("input stalled while the result register is free");

   a_bad_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STATUS_BAD)) |=> (status_ff == STATUS_BAD))
      else $error("malformed status cleared without reset");

   a_done_in_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STATUS_DONE)) |-> (phase_ff == PHASE_CODE_BODY))
      else $error("request complete outside the body phase");

endmodule

FILE: dv/hrsp_result_checker.sv
// hrsp_result_checker: watches both channels of the HTTP request stream parser,
// predicts the result of every accepted byte and compares it field by field.
// Depends on hrsp_pkg.
`timescale 1ns / 1ps

module hrsp_result_checker
   import hrsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [1:0]  rsp_phase,
   input  logic        rsp_persist,
   input  logic [31:0] rsp_decl_length,
   input  logic [15:0] rsp_method_len,
   input  logic [15:0] rsp_url_start,
   input  logic [15:0] rsp_url_len,
   input  logic [15:0] rsp_version_start,
   input  logic [15:0] rsp_version_len,
   input  logic [15:0] rsp_host_start,
   input  logic [15:0] rsp_host_len,
   output int          error_count,
   output int          pending_count
);

   localparam logic [15:0] POS_LAST = 16'hFFFF;
   localparam logic [31:0] LEN_LAST = 32'hFFFF_FFFF;

   // Span register slots
   localparam int SPAN_METHOD_LEN  = 0;
   localparam int SPAN_URL_START   = 1;
   localparam int SPAN_URL_LEN     = 2;
   localparam int SPAN_VER_START   = 3;
   localparam int SPAN_VER_LEN     = 4;
   localparam int SPAN_HOST_START  = 5;
   localparam int SPAN_HOST_LEN    = 6;
   localparam int SPAN_VALUE_START = 7;

   // Recognised header names, one match bit each
   localparam int HDR_CONN = 0;
   localparam int HDR_CLEN = 1;
   localparam int HDR_HOST = 2;

   // Position within the current line
   typedef enum logic [1:0] {
      SEG_FIRST,
      SEG_SECOND,
      SEG_THIRD
   } seg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  phase;
      logic        persist;
      logic [31:0] decl_length;
      logic [15:0] method_len;
      logic [15:0] url_start;
      logic [15:0] url_len;
      logic [15:0] version_start;
      logic [15:0] version_len;
      logic [15:0] host_start;
      logic [15:0] host_len;
   } parse_snapshot_type;

   parse_snapshot_type parse_snapshots[$];

   // Parser state as the predictor sees it
   logic [15:0] byte_pos;
   logic [15:0] line_begin;
   logic [1:0]  parse_ph;
   seg_type     seg;
   logic        cr_seen;
   logic        broken;
   logic [3:0]  name_idx;
   logic [2:0]  name_hits;
   logic [3:0]  val_idx;
   logic        ka_hit;
   logic        digits_on;
   logic [31:0] len_acc;
   logic [31:0] body_seen;
   logic [31:0] body_len;
   logic [15:0] spans [8];
   logic        persist_q;

   function automatic logic space_or_tab(logic [7:0] c);
      return (c == CHAR_SP) || (c == CHAR_TAB);
   endfunction

   function automatic string header_text(int hdr);
      case (hdr)
         HDR_CONN: return "Connection";
         HDR_CLEN: return "Content-Length";
         default:  return "Host";
      endcase
   endfunction

   function automatic void clear_line_match();
      name_idx  = '0;
      name_hits = 3'b111;
      val_idx   = '0;
      ka_hit    = 1'b1;
      digits_on = 1'b1;
      len_acc   = '0;
   endfunction

   function automatic void clear_parse_state();
      byte_pos     = '0;
      line_begin   = '0;
      parse_ph     = PHASE_CODE_REQ;
      seg          = SEG_FIRST;
      cr_seen      = 1'b0;
      broken       = 1'b0;
      body_seen    = '0;
      body_len     = '0;
      persist_q    = 1'b0;
      foreach (spans[k]) spans[k] = '0;
      clear_line_match();
   endfunction

   // Header value byte: keep-alive match and decimal length accumulation
   function automatic void take_value_byte(logic [7:0] c);
      string       ka = "keep-alive";
      logic [63:0] digit;
      if (ka_hit && (val_idx >= KA_LEN || c != ka[val_idx])) ka_hit = 1'b0;
      if (val_idx < MATCH_IDX_MAX) val_idx++;
      if (digits_on) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            digit = 64'(c - CHAR_ZERO);
            if (64'(len_acc) > (64'(LEN_LAST) - digit) / 64'd10) len_acc = LEN_LAST;
            else len_acc = 32'(64'(len_acc) * 64'd10 + digit);
         end else begin
            digits_on = 1'b0;
         end
      end
   endfunction

   // Ordinary byte of the request line or of a header line
   function automatic void take_line_byte(logic [7:0] c, logic [15:0] p);
      string txt;
      if (parse_ph == PHASE_CODE_REQ) begin
         if (seg == SEG_FIRST && space_or_tab(c)) begin
            spans[SPAN_METHOD_LEN] = p - line_begin;
            spans[SPAN_URL_START]  = p + 16'd1;
            seg = SEG_SECOND;
         end else if (seg == SEG_SECOND && space_or_tab(c)) begin
            spans[SPAN_URL_LEN]   = p - spans[SPAN_URL_START];
            spans[SPAN_VER_START] = p + 16'd1;
            seg = SEG_THIRD;
         end
      end else if (seg == SEG_FIRST) begin
         if (c == CHAR_COLON) begin
            for (int k = 0; k < 3; k++) begin
               txt = header_text(k);
               if (int'(name_idx) != txt.len()) name_hits[k] = 1'b0;
            end
            seg = SEG_SECOND;
         end else begin
            for (int k = 0; k < 3; k++) begin
               txt = header_text(k);
               if (int'(name_idx) >= txt.len() || c != txt[name_idx]) name_hits[k] = 1'b0;
            end
            if (name_idx < MATCH_IDX_MAX) name_idx++;
         end
      end else begin
         // leading blanks of a value are skipped
         if (seg == SEG_SECOND && !space_or_tab(c)) begin
            spans[SPAN_VALUE_START] = p;
            seg = SEG_THIRD;
         end
         if (seg == SEG_THIRD) take_value_byte(c);
      end
   endfunction

   // CR LF seen: close the request line, a header line or the header block
   function automatic void close_line(logic [15:0] crpos, logic [15:0] p);
      if (parse_ph == PHASE_CODE_REQ) begin
         if (seg != SEG_THIRD) begin
            broken = 1'b1;
            return;
         end
         spans[SPAN_VER_LEN] = crpos - spans[SPAN_VER_START];
         parse_ph = PHASE_CODE_HDR;
      end else if (crpos == line_begin) begin
         parse_ph  = PHASE_CODE_BODY;
         body_seen = '0;
      end else if (seg != SEG_THIRD) begin
         broken = 1'b1;
         return;
      end else begin
         if (name_hits[HDR_CONN]) persist_q = ka_hit && (val_idx == KA_LEN);
         if (name_hits[HDR_CLEN]) body_len = len_acc;
         if (name_hits[HDR_HOST]) begin
            spans[SPAN_HOST_START] = spans[SPAN_VALUE_START];
            spans[SPAN_HOST_LEN]   = crpos - spans[SPAN_VALUE_START];
         end
      end
      seg        = SEG_FIRST;
      line_begin = p + 16'd1;
      clear_line_match();
   endfunction

   // One byte into the parser, giving the result it must report
   function automatic parse_snapshot_type advance_parser(logic [7:0] c);
      parse_snapshot_type s;
      logic [15:0]        p;
      if (!broken) begin
         if (parse_ph == PHASE_CODE_BODY) begin
            if (body_seen < body_len) body_seen++;
         end else if (byte_pos == POS_LAST) begin
            broken = 1'b1;
         end else begin
            p = byte_pos;
            byte_pos = p + 16'd1;
            if (cr_seen) begin
               cr_seen = 1'b0;
               if (c == CHAR_LF) close_line(p - 16'd1, p);
               else broken = 1'b1;
            end else if (c == CHAR_CR) begin
               cr_seen = 1'b1;
            end else begin
               take_line_byte(c, p);
            end
         end
      end
      if (broken) s.status = STATUS_BAD;
      else if (parse_ph == PHASE_CODE_BODY && body_seen >= body_len) s.status = STATUS_DONE;
      else s.status = STATUS_PENDING;
      s.phase          = parse_ph;
      s.persist        = persist_q;
      s.decl_length    = body_len;
      s.method_len     = spans[SPAN_METHOD_LEN];
      s.url_start      = spans[SPAN_URL_START];
      s.url_len        = spans[SPAN_URL_LEN];
      s.version_start  = spans[SPAN_VER_START];
      s.version_len    = spans[SPAN_VER_LEN];
      s.host_start     = spans[SPAN_HOST_START];
      s.host_len       = spans[SPAN_HOST_LEN];
      return s;
   endfunction

   function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   initial begin
      clear_parse_state();
   end

   // Result first (it belongs to an older byte), then the new request byte
   always @(posedge clock) begin
      parse_snapshot_type want;
      int bad;
      bad = 0;
      if (reset) begin
         clear_parse_state();
         parse_snapshots.delete();
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parse_snapshots.size() == 0) begin
               $display("%0t: result transaction with no prediction waiting", $time);
               bad++;
            end else begin
               want = parse_snapshots.pop_front();
               bad += field_differs("status", 32'(want.status), 32'(rsp_status));
               bad += field_differs("phase", 32'(want.phase), 32'(rsp_phase));
               bad += field_differs("persist", 32'(want.persist), 32'(rsp_persist));
               bad += field_differs("decl_length", want.decl_length, rsp_decl_length);
               bad += field_differs("method_len", 32'(want.method_len), 32'(rsp_method_len));
               bad += field_differs("url_start", 32'(want.url_start), 32'(rsp_url_start));
               bad += field_differs("url_len", 32'(want.url_len), 32'(rsp_url_len));
               bad += field_differs("version_start", 32'(want.version_start),
                                    32'(rsp_version_start));
               bad += field_differs("version_len", 32'(want.version_len), 32'(rsp_version_len));
               bad += field_differs("host_start", 32'(want.host_start), 32'(rsp_host_start));
               bad += field_differs("host_len", 32'(want.host_len), 32'(rsp_host_len));
            end
         end
         if (req_valid && !req_stall) parse_snapshots.push_back(advance_parser(req_data_byte));
         error_count   <= error_count + bad;
         pending_count <= parse_snapshots.size();
      end
   end

endmodule

FILE: dv/tb_top.sv
// tb_top: builds one HTTP request byte stream, drives it into the parser under
// changing idle and stall pressure, and gives the verdict.
// Depends on hrsp_pkg, http_request_stream_parser, hrsp_result_checker.
`timescale 1ns / 1ps

module tb_top;
   import hrsp_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_BYTES = 800;

   // How the stream ends
   typedef enum int {
      END_COMPLETE,
      END_BARE_CR,
      END_NO_COLON,
      END_BLANK_VALUE,
      END_BAD_REQ_LINE
   } stream_end_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_phase;
   logic        rsp_persist;
   logic [31:0] rsp_decl_length;
   logic [15:0] rsp_method_len;
   logic [15:0] rsp_url_start;
   logic [15:0] rsp_url_len;
   logic [15:0] rsp_version_start;
   logic [15:0] rsp_version_len;
   logic [15:0] rsp_host_start;
   logic [15:0] rsp_host_len;
   int          error_count;
   int          pending_count;

   logic [7:0]  request_bytes[$];
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          quiet_cycles = 0;

   always #4 clock = ~clock;

   http_request_stream_parser uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_phase          (rsp_phase),
      .rsp_persist        (rsp_persist),
      .rsp_decl_length    (rsp_decl_length),
      .rsp_method_len     (rsp_method_len),
      .rsp_url_start      (rsp_url_start),
      .rsp_url_len        (rsp_url_len),
      .rsp_version_start  (rsp_version_start),
      .rsp_version_len    (rsp_version_len),
      .rsp_host_start     (rsp_host_start),
      .rsp_host_len       (rsp_host_len)
   );

   hrsp_result_checker watch (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_phase          (rsp_phase),
      .rsp_persist        (rsp_persist),
      .rsp_decl_length    (rsp_decl_length),
      .rsp_method_len     (rsp_method_len),
      .rsp_url_start      (rsp_url_start),
      .rsp_url_len        (rsp_url_len),
      .rsp_version_start  (rsp_version_start),
      .rsp_version_len    (rsp_version_len),
      .rsp_host_start     (rsp_host_start),
      .rsp_host_len       (rsp_host_len),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // Receiver back-pressure
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Byte generators and stream builders
   function automatic logic [7:0] byte_not_cr();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
      return b;
   endfunction

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      do b = byte_not_cr(); while (b == CHAR_COLON);
      return b;
   endfunction

   function automatic logic [7:0] solid_byte();
      logic [7:0] b;
      do b = byte_not_cr(); while (b == CHAR_SP || b == CHAR_TAB);
      return b;
   endfunction

   function automatic void put_text(string s);
      for (int k = 0; k < s.len(); k++) request_bytes.push_back(s[k]);
   endfunction

   function automatic void put_crlf();
      request_bytes.push_back(CHAR_CR);
      request_bytes.push_back(CHAR_LF);
   endfunction

   function automatic void put_blanks();
      repeat ($urandom_range(0, 3))
         request_bytes.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
   endfunction

   function automatic void put_digits(int n);
      repeat (n) request_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
   endfunction

   // header value: first byte non-blank, the rest anything but CR
   function automatic void put_value(int n);
      request_bytes.push_back(solid_byte());
      repeat (n - 1) request_bytes.push_back(byte_not_cr());
   endfunction

   function automatic void put_noise();
      repeat (10) request_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // One well-formed header line, biased towards the recognised names
   function automatic void add_header();
      string conn_alts[6];
      string clen_alts[8];
      string name_alts[8];
      conn_alts = '{"Keep-Alive", "keep-alive ", "keep-alivex", "close", "keep-aliv",
                    "keep-alive\tx"};
      clen_alts = '{"4294967295", "4294967296", "42949672950", "+12", "-7", "12ab", "x5",
                    "007 1"};
      name_alts = '{"connection", "Connectio", "Connectionx", "Host ", "Hostname",
                    "Content-Lengthy", "Content-Lengt", "X-Very-Long-Header-Name"};
      case ($urandom_range(0, 11))
         0: begin
            put_text("Connection:");
            put_blanks();
            put_text("keep-alive");
         end
         1: begin
            put_text("Connection:");
            put_blanks();
            put_text(conn_alts[$urandom_range(0, 5)]);
         end
         2: begin
            put_text("Content-Length:");
            put_blanks();
            put_digits($urandom_range(1, 4));
         end
         3: begin
            put_text("Content-Length:");
            put_blanks();
            put_digits($urandom_range(9, 14));
         end
         4: begin
            put_text("Content-Length:");
            put_blanks();
            put_text(clen_alts[$urandom_range(0, 7)]);
         end
         5: begin
            put_text("Host:");
            put_blanks();
            put_value($urandom_range(1, 16));
         end
         6: begin
            put_text(name_alts[$urandom_range(0, 7)]);
            request_bytes.push_back(CHAR_COLON);
            put_blanks();
            put_value($urandom_range(1, 12));
         end
         default: begin
            repeat ($urandom_range(0, 12)) request_bytes.push_back(name_byte());
            request_bytes.push_back(CHAR_COLON);
            put_blanks();
            put_value($urandom_range(1, 20));
         end
      endcase
      put_crlf();
   endfunction

   initial begin
      stream_end_type ending;
      int             pick;
      int             body_bytes;
      int             i;
      int             leftover;

      // Choose how this run's stream ends
      pick = $urandom_range(0, 11);
      case (pick)
         5:       ending = END_BARE_CR;
         6:       ending = END_NO_COLON;
         7:       ending = END_BLANK_VALUE;
         9:       ending = END_BAD_REQ_LINE;
         default: ending = END_COMPLETE;
      endcase

      if (ending == END_BAD_REQ_LINE) begin
         // request line with the method or URL never terminated
         repeat ($urandom_range(1, 8)) request_bytes.push_back(solid_byte());
         if ($urandom_range(0, 1)) request_bytes.push_back(CHAR_SP);
         repeat (RANDOM_BYTES) request_bytes.push_back(solid_byte());
         put_crlf();
         put_noise();
      end else begin
         // Directed request line: tab and blank separators, byte extremes in the URL,
         // a lone LF inside the version text
         put_text("GET\t/");
         request_bytes.push_back(8'h00);
         request_bytes.push_back(8'hFF);
         put_text(" HT\nTP/1.1");
         put_crlf();

         while (request_bytes.size() < RANDOM_BYTES) add_header();

         case (ending)
            END_COMPLETE: begin
               body_bytes = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
               put_text($sformatf("Content-Length: %0d", body_bytes));
               put_crlf();
               put_crlf();
               repeat (body_bytes) request_bytes.push_back(8'($urandom_range(0, 255)));
            end
            END_BARE_CR: begin
               put_text("X-A: v");
               request_bytes.push_back(CHAR_CR);
               do pick = $urandom_range(0, 255); while (pick == CHAR_LF);
               request_bytes.push_back(8'(pick));
            end
            END_NO_COLON: begin
               repeat ($urandom_range(1, 10)) request_bytes.push_back(name_byte());
               put_crlf();
            end
            END_BLANK_VALUE: begin
               put_text("Host:");
               put_blanks();
               put_crlf();
            end
            default: ;
         endcase
         put_noise();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drive the stream; pressure changes every hundred bytes
      for (i = 0; i < request_bytes.size(); i++) begin
         case ((i / 100) % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
            default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
         endcase
         while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= request_bytes[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for strays
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      leftover = pending_count;
      if (leftover != 0) $display("%0t: %0d predicted results never arrived", $time, leftover);

      $display("summary: %0d request bytes driven, stream ending %s", request_bytes.size(),
               ending.name());
      $display("summary: final status %0d, phase %0d, content length %0d", rsp_status,
               rsp_phase, rsp_decl_length);
      if (error_count == 0 && leftover == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
